>>> design/prbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbc_pkg
// Shared types and constants for the contiguous packet ring buffer.
// ----------------------------------------------------------------------------
package prbc_pkg;

  // Field widths of the request and result items
  localparam int LEN_W     = 13;
  localparam int OP_W      = 3;
  localparam int ST_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int OFF_W     = 12;
  localparam int CNT_OUT_W = 7;

  // Reset value of the buffer length register
  localparam logic [LEN_W-1:0] BUF_LEN_RST = 13'd4096;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_START = 3'd0,
    OP_PUSH_BYTE  = 3'd1,
    OP_READ_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_RESET      = 3'd4
  } prbc_op_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK             = 3'd0,
    ST_EMPTY          = 3'd1,
    ST_NO_SPACE       = 3'd2,
    ST_BAD_LENGTH     = 3'd3,
    ST_NO_RESERVATION = 3'd4
  } prbc_status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_FETCH = 4'b0100,
    S_DONE  = 4'b1000
  } prbc_state_t;

  // Commands to the descriptor queue
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } prbc_dq_cmd_t;

endpackage

>>> design/packet_ring_buffer_contiguous_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_ring_buffer_contiguous_core
// Byte store of variable-length packets, each kept contiguous, with a
// descriptor queue recording (begin, length) of every queued packet.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | sink      | in_tvalid / in_tready | in_tuser op, in_tdata fields
//  out_    | source    | out_tvalid/out_tready | out_tuser status, out_tdata
//  cfg_    | sink      | cfg_wr_en             | cfg_wr_data buffer length
//
// A request passes from acceptance (with byte store read) to execute and to
// result load; a pop that leaves packets queued adds a fetch state, as the
// new front descriptor is read from the descriptor memory.
// in_tready is high only while the sequencer is idle, one request at a time.
// A result held by out_tready low stalls the sequencer in its last state.
// rst_n (synchronous) clears all counters and pointers; no clearing pass.
// ----------------------------------------------------------------------------
module packet_ring_buffer_contiguous_core #(
  parameter int STORE_BYTES = 4096,
  parameter int MAX_PACKETS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // packet_length[12:0], data_byte[20:13],
                                  // read_offset[32:21], zero[39:33]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_byte[7:0], front_length[20:8],
                                  // packet_count[27:21], free_bytes[40:28],
                                  // zero[47:41]
  output logic [2:0]  out_tuser,  // status[2:0]
  // configuration
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data // buffer_length
);

  localparam int LEN_W  = prbc_pkg::LEN_W;
  localparam int BYTE_W = prbc_pkg::BYTE_W;
  localparam int OFF_W  = prbc_pkg::OFF_W;
  localparam int ST_W   = prbc_pkg::ST_W;
  localparam int AW     = $clog2(STORE_BYTES);
  localparam int CW     = $clog2(MAX_PACKETS + 1);
  localparam int PTR_W  = (AW > LEN_W) ? AW : LEN_W;
  localparam int SUM_W  = PTR_W + 1;
  localparam int SB_W   = LEN_W + CW;
  localparam int LEN_MAX   = (1 << LEN_W) - 1;
  localparam int STORE_LIM = (STORE_BYTES > LEN_MAX) ? LEN_MAX : STORE_BYTES;

  // ---- request fields
  logic [LEN_W-1:0]  in_len;
  logic [BYTE_W-1:0] in_data;
  logic [OFF_W-1:0]  in_off;
  assign in_len  = in_tdata[12:0];
  assign in_data = in_tdata[20:13];
  assign in_off  = in_tdata[32:21];

  // ---- state
  prbc_pkg::prbc_state_t state_r, state_nxt;
  logic [2:0]        op_r;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] data_r;
  logic [OFF_W-1:0]  off_r;
  logic [LEN_W-1:0]  buf_len_r;
  logic [LEN_W-1:0]  write_end_r, write_end_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [LEN_W-1:0]  pending_r, pending_nxt;
  logic [SB_W-1:0]   stored_r, stored_nxt;
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic [BYTE_W-1:0] res_byte_r, res_byte_nxt;
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [LEN_W-1:0]  out_front_r;
  logic [6:0]        out_count_r;
  logic [LEN_W-1:0]  out_free_r;

  // ---- byte store
  logic [BYTE_W-1:0] byte_mem [STORE_BYTES];
  logic [BYTE_W-1:0] byte_q_r;
  logic              byte_we;
  logic [SUM_W-1:0]  rd_addr;

  // ---- descriptor queue
  prbc_pkg::prbc_dq_cmd_t dq_cmd;
  logic [AW-1:0]     dq_push_begin;
  logic [CW-1:0]     dq_count;
  logic              dq_full;
  logic [AW-1:0]     dq_front_begin;
  logic [LEN_W-1:0]  dq_front_len;

  logic in_acc;
  logic out_free_slot;
  assign in_tready     = (state_r == prbc_pkg::S_IDLE);
  assign in_acc        = in_tvalid && in_tready;
  assign out_free_slot = !out_valid_r || out_tready;

  // Effective buffer length, capped at the store size
  logic [LEN_W-1:0] eff_len;
  assign eff_len = (buf_len_r > LEN_W'(STORE_LIM)) ? LEN_W'(STORE_LIM) : buf_len_r;

  // Byte store read address for read_front, issued at acceptance
  assign rd_addr = SUM_W'(dq_front_begin) + SUM_W'(in_off);

  // ---- execute stage
  logic [LEN_W-1:0] room, we_wrap, room_wrap;
  logic             wrap;
  logic [PTR_W-1:0] start_w, wew_w, len_w;
  logic             fits;

  always_comb begin
    room      = eff_len - write_end_r;
    wrap      = (write_end_r > eff_len) || (room < len_r);
    we_wrap   = wrap ? '0 : write_end_r;
    room_wrap = eff_len - we_wrap;
    start_w   = PTR_W'(dq_front_begin);
    wew_w     = PTR_W'(we_wrap);
    len_w     = PTR_W'(len_r);
    // space check against the oldest packet's begin
    priority if (dq_count == '0) begin
      fits = 1'b1;
    end else if (we_wrap == '0) begin
      fits = (start_w >= len_w);
    end else if (start_w >= wew_w) begin
      fits = ((start_w - wew_w) >= len_w);
    end else begin
      fits = (room_wrap >= len_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    write_end_nxt  = write_end_r;
    wr_ptr_nxt     = wr_ptr_r;
    pending_nxt    = pending_r;
    stored_nxt     = stored_r;
    res_status_nxt = res_status_r;
    res_byte_nxt   = res_byte_r;
    dq_cmd         = '0;
    dq_push_begin  = AW'(we_wrap);
    byte_we        = 1'b0;

    unique case (state_r)
      prbc_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = prbc_pkg::S_EXEC;
        end
      end
      prbc_pkg::S_EXEC: begin
        state_nxt      = prbc_pkg::S_DONE;
        res_status_nxt = prbc_pkg::ST_OK;
        res_byte_nxt   = '0;
        unique case (op_r)
          prbc_pkg::OP_PUSH_START: begin
            if (len_r == '0 || len_r > eff_len) begin
              res_status_nxt = prbc_pkg::ST_BAD_LENGTH;
            end else begin
              // the wrap sticks even when the push is refused
              write_end_nxt = we_wrap;
              if (dq_full || !fits) begin
                res_status_nxt = prbc_pkg::ST_NO_SPACE;
              end else begin
                dq_cmd.push   = 1'b1;
                stored_nxt    = stored_r + SB_W'(len_r);
                wr_ptr_nxt    = wew_w;
                pending_nxt   = len_r;
                write_end_nxt = we_wrap + len_r;
              end
            end
          end
          prbc_pkg::OP_PUSH_BYTE: begin
            if (pending_r == '0) begin
              res_status_nxt = prbc_pkg::ST_NO_RESERVATION;
            end else begin
              byte_we     = (SUM_W'(wr_ptr_r) < SUM_W'(STORE_BYTES));
              wr_ptr_nxt  = wr_ptr_r + 1'b1;
              pending_nxt = pending_r - 1'b1;
            end
          end
          prbc_pkg::OP_READ_FRONT: begin
            if (dq_count == '0) begin
              res_status_nxt = prbc_pkg::ST_EMPTY;
            end else if (LEN_W'(off_r) >= dq_front_len) begin
              res_status_nxt = prbc_pkg::ST_BAD_LENGTH;
            end else begin
              res_byte_nxt = byte_q_r;
            end
          end
          prbc_pkg::OP_POP_FRONT: begin
            if (dq_count == '0) begin
              res_status_nxt = prbc_pkg::ST_EMPTY;
            end else begin
              dq_cmd.pop = 1'b1;
              stored_nxt = (stored_r >= SB_W'(dq_front_len)) ?
                           stored_r - SB_W'(dq_front_len) : '0;
              if (dq_count == CW'(1)) begin
                write_end_nxt = '0;
                pending_nxt   = '0;
              end else begin
                state_nxt = prbc_pkg::S_FETCH;
              end
            end
          end
          prbc_pkg::OP_RESET: begin
            dq_cmd.clear  = 1'b1;
            write_end_nxt = '0;
            wr_ptr_nxt    = '0;
            pending_nxt   = '0;
            stored_nxt    = '0;
          end
          default: begin
          end
        endcase
      end
      prbc_pkg::S_FETCH: begin
        state_nxt = prbc_pkg::S_DONE;
      end
      prbc_pkg::S_DONE: begin
        if (out_free_slot) begin
          state_nxt = prbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = prbc_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prbc_pkg::S_IDLE;
      buf_len_r   <= prbc_pkg::BUF_LEN_RST;
      write_end_r <= '0;
      wr_ptr_r    <= '0;
      pending_r   <= '0;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      write_end_r <= write_end_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      pending_r   <= pending_nxt;
      stored_r    <= stored_nxt;
      if (cfg_wr_en) begin
        buf_len_r <= cfg_wr_data;
      end
      if (state_r == prbc_pkg::S_DONE && out_free_slot) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_byte_r   <= res_byte_nxt;
    if (in_acc) begin
      op_r   <= in_tuser;
      len_r  <= in_len;
      data_r <= in_data;
      off_r  <= in_off;
    end
    if (state_r == prbc_pkg::S_DONE && out_free_slot) begin
      out_status_r <= res_status_r;
      out_byte_r   <= res_byte_r;
      out_front_r  <= (dq_count == '0) ? '0 : dq_front_len;
      out_count_r  <= 7'(dq_count);
      out_free_r   <= (SB_W'(eff_len) > stored_r) ?
                      LEN_W'(SB_W'(eff_len) - stored_r) : '0;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[wr_ptr_r[AW-1:0]] <= data_r;
    end
    if (in_acc) begin
      byte_q_r <= byte_mem[rd_addr[AW-1:0]];
    end
  end

  prbc_desc_queue #(
    .MAX_PACKETS (MAX_PACKETS),
    .AW          (AW)
  ) u_desc_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dq_cmd),
    .push_begin  (dq_push_begin),
    .push_len    (len_r),
    .count       (dq_count),
    .full        (dq_full),
    .front_begin (dq_front_begin),
    .front_len   (dq_front_len)
  );

  // Result channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_free_r, out_count_r, out_front_r, out_byte_r};

endmodule

>>> design/prbc_desc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbc_desc_queue
// Circular queue of packet descriptors (begin, length) in one synchronous
// memory, with the front descriptor cached in registers. A pop that leaves
// descriptors queued refills the cache from memory via the read register.
// ----------------------------------------------------------------------------
module prbc_desc_queue #(
  parameter int MAX_PACKETS = 64,
  parameter int AW          = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prbc_pkg::prbc_dq_cmd_t      cmd,
  input  logic [AW-1:0]               push_begin,
  input  logic [prbc_pkg::LEN_W-1:0]  push_len,
  output logic [$clog2(MAX_PACKETS+1)-1:0] count,
  output logic                        full,
  output logic [AW-1:0]               front_begin,
  output logic [prbc_pkg::LEN_W-1:0]  front_len
);

  localparam int QW = $clog2(MAX_PACKETS);
  localparam int CW = $clog2(MAX_PACKETS + 1);
  localparam int DW = AW + prbc_pkg::LEN_W;

  logic [DW-1:0] desc_mem [MAX_PACKETS];
  logic [DW-1:0] rd_q_r;

  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          fetch_r, fetch_nxt;
  logic [AW-1:0] front_begin_r, front_begin_nxt;
  logic [prbc_pkg::LEN_W-1:0] front_len_r, front_len_nxt;
  logic          rd_en;

  function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] i);
    next_slot = (i == QW'(MAX_PACKETS - 1)) ? '0 : i + 1'b1;
  endfunction

  // Pointer, count and front cache update
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    front_begin_nxt = front_begin_r;
    front_len_nxt   = front_len_r;
    rd_en           = 1'b0;
    fetch_nxt       = 1'b0;
    if (fetch_r) begin
      front_begin_nxt = rd_q_r[DW-1 -: AW];
      front_len_nxt   = rd_q_r[prbc_pkg::LEN_W-1:0];
    end
    priority if (cmd.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.push) begin
      tail_nxt  = next_slot(tail_r);
      count_nxt = count_r + 1'b1;
      if (count_r == '0) begin
        front_begin_nxt = push_begin;
        front_len_nxt   = push_len;
      end
    end else if (cmd.pop) begin
      head_nxt  = next_slot(head_r);
      count_nxt = count_r - 1'b1;
      if (count_r > CW'(1)) begin
        rd_en     = 1'b1;
        fetch_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      fetch_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      fetch_r <= fetch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_begin_r <= front_begin_nxt;
    front_len_r   <= front_len_nxt;
  end

  // Descriptor memory: write at tail, read next head on pop
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      desc_mem[tail_r] <= {push_begin, push_len};
    end
    if (rd_en) begin
      rd_q_r <= desc_mem[head_nxt];
    end
  end

  assign count       = count_r;
  assign full        = (count_r >= CW'(MAX_PACKETS));
  assign front_begin = front_begin_r;
  assign front_len   = front_len_r;

endmodule
